// File: rtl/tsg_pkg.sv
// Shared types and codes for the touch swipe gesture classifier.
// No dependencies; every other file in rtl/ imports this package.
package tsg_pkg;

  localparam logic [31:0] THR_RESET   = 32'd400;
  localparam logic [3:0]  ANGLE_RESET = 4'd3;

  // Register select: bit 2 of the byte address
  localparam logic REG_SLIDE_THR = 1'b0;
  localparam logic REG_ANGLE     = 1'b1;

  localparam logic [7:0] EV_IDLE0 = 8'h00;
  localparam logic [7:0] EV_FIRST = 8'h01;
  localparam logic [7:0] EV_IDLE2 = 8'h02;
  localparam logic [7:0] EV_HELD  = 8'h03;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_HELD  = 2'd2;
  localparam logic [1:0] PH_REL   = 2'd3;

  localparam logic [1:0] SM_UNTOUCHED = 2'd0;
  localparam logic [1:0] SM_NOSLIDE   = 2'd1;
  localparam logic [1:0] SM_VERT      = 2'd2;
  localparam logic [1:0] SM_HORZ      = 2'd3;

  localparam logic [2:0] G_UNTOUCHED = 3'd0;
  localparam logic [2:0] G_NOSLIDE   = 3'd1;
  localparam logic [2:0] G_CLICK     = 3'd4;
  localparam logic [2:0] G_VFLING    = 3'd5;
  localparam logic [2:0] G_HFLING    = 3'd6;

  localparam int IN_W  = 72;
  localparam int OUT_W = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_MW,
    ST_DEC
  } st_t;

  typedef enum logic [1:0] {
    MUL_SQX,
    MUL_SQY,
    MUL_WY
  } mul_sel_t;

  typedef struct packed {
    logic               report_ready;
    logic [7:0]         event_code;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        displayed_page;
    logic [15:0]        query_page;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         gesture;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic [1:0]         touch_phase;
  } res_t;

endpackage

// File: rtl/tsg_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on tsg_pkg for reset values and register selects.
module tsg_cfg import tsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [31:0] slide_thr,
  output logic [3:0]  angle
);

  logic [31:0] thr_r, thr_nxt;
  logic [3:0]  angle_r, angle_nxt;
  logic        wr_en;

  assign wr_en = psel & penable & pwrite;

  always_comb begin
    thr_nxt   = thr_r;
    angle_nxt = angle_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SLIDE_THR: thr_nxt   = pwdata;
        REG_ANGLE:     angle_nxt = pwdata[3:0];
        default:       thr_nxt   = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      angle_r <= ANGLE_RESET;
    end else begin
      thr_r   <= thr_nxt;
      angle_r <= angle_nxt;
    end
  end

  assign prdata    = (paddr[2] == REG_ANGLE) ? {28'd0, angle_r} : thr_r;
  assign slide_thr = thr_r;
  assign angle     = angle_r;

endmodule

// File: rtl/tsg_mul.sv
// Shared 32x16 multiplier with registered product: squares both distances,
// then weights the Y square by the angle factor. Depends on tsg_pkg.
module tsg_mul import tsg_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  mul_sel_t    sel,
  input  logic [15:0] mag_x,
  input  logic [15:0] mag_y,
  input  logic [3:0]  angle,
  output logic [47:0] prod_r
);

  logic [31:0] op_a;
  logic [15:0] op_b;
  logic [47:0] prod_nxt;

  // Weighting pass feeds the Y square straight back from the product register
  always_comb begin
    unique case (sel)
      MUL_SQX: begin
        op_a = {16'd0, mag_x};
        op_b = mag_x;
      end
      MUL_SQY: begin
        op_a = {16'd0, mag_y};
        op_b = mag_y;
      end
      MUL_WY: begin
        op_a = prod_r[31:0];
        op_b = {12'd0, angle};
      end
      default: begin
        op_a = {16'd0, mag_x};
        op_b = mag_x;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  // Hold the product outside the three passes
  always_ff @(posedge clk) begin
    if (en) prod_r <= prod_nxt;
  end

endmodule

// File: rtl/tsg_ctrl.sv
// Sequencer and gesture state: latches a report, runs three multiplier
// passes, then classifies. Depends on tsg_pkg; drives tsg_mul's select.
module tsg_ctrl import tsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_acc,
  input  in_item_t    item,
  output logic        in_ready,
  input  logic [31:0] slide_thr,
  input  logic        out_free,
  output logic        res_valid,
  output res_t        res,
  output logic        mul_en,
  output mul_sel_t    mul_sel,
  output logic [15:0] mag_x,
  output logic [15:0] mag_y,
  input  logic [47:0] prod
);

  st_t st_r, st_nxt;

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  sm_r, sm_nxt;
  logic [15:0] press_x_r, press_x_nxt, press_y_r, press_y_nxt;
  logic [15:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [15:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [15:0] press_page_r, press_page_nxt;
  logic [15:0] fling_x_r, fling_x_nxt, fling_y_r, fling_y_nxt;
  logic [15:0] dpage_r, qpage_r;
  logic [31:0] x2_r, y2_r;

  logic [15:0] diff_x, diff_y, spd_x, spd_y;
  logic        moved, vert, dec_fire;
  logic [1:0]  dir, sm_dec;
  logic [2:0]  gest;
  logic        upd_fx, upd_fy, page_ld;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_MX;
      ST_MX:   st_nxt = ST_MY;
      ST_MY:   st_nxt = ST_MW;
      ST_MW:   st_nxt = ST_DEC;
      ST_DEC:  if (out_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    dec_fire  = 1'b0;
    mul_en    = 1'b0;
    mul_sel   = MUL_SQX;
    unique case (st_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MX: begin
        mul_en  = 1'b1;
        mul_sel = MUL_SQX;
      end
      ST_MY: begin
        mul_en  = 1'b1;
        mul_sel = MUL_SQY;
      end
      ST_MW: begin
        mul_en  = 1'b1;
        mul_sel = MUL_WY;
      end
      ST_DEC:  dec_fire = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign res_valid = dec_fire;

  // Wrapped press-to-current distances, magnitude in 16 bits (0x8000 stays)
  assign diff_x = press_x_r - cur_x_r;
  assign diff_y = press_y_r - cur_y_r;
  assign mag_x  = diff_x[15] ? 16'(~diff_x + 16'd1) : diff_x;
  assign mag_y  = diff_y[15] ? 16'(~diff_y + 16'd1) : diff_y;

  assign spd_x = prev_x_r - cur_x_r;
  assign spd_y = prev_y_r - cur_y_r;

  // In ST_DEC the product register holds angle * y^2
  assign moved = (y2_r >= slide_thr) || (x2_r >= slide_thr);
  assign vert  = prod[35:0] >= {4'd0, x2_r};
  assign dir   = vert ? SM_VERT : SM_HORZ;

  always_comb begin
    gest    = G_UNTOUCHED;
    sm_dec  = sm_r;
    upd_fx  = 1'b0;
    upd_fy  = 1'b0;
    page_ld = 1'b0;
    priority if (phase_r == PH_IDLE) begin
      sm_dec = SM_UNTOUCHED;
      gest   = G_UNTOUCHED;
    end else if (phase_r == PH_FIRST) begin
      page_ld = 1'b1;
      sm_dec  = SM_NOSLIDE;
      gest    = G_NOSLIDE;
    end else if (qpage_r != press_page_r) begin
      gest = G_NOSLIDE;
    end else if (phase_r == PH_HELD) begin
      if (sm_r == SM_NOSLIDE && moved) sm_dec = dir;
      gest = {1'b0, sm_dec};
    end else if (sm_r == SM_NOSLIDE && !moved) begin
      gest = G_CLICK;
    end else begin
      if (sm_r == SM_NOSLIDE) sm_dec = dir;
      // untouched on release falls through as horizontal
      if (sm_dec == SM_VERT) begin
        upd_fy = 1'b1;
        gest   = G_VFLING;
      end else begin
        upd_fx = 1'b1;
        gest   = G_HFLING;
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    sm_nxt         = sm_r;
    press_x_nxt    = press_x_r;
    press_y_nxt    = press_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    press_page_nxt = press_page_r;
    fling_x_nxt    = fling_x_r;
    fling_y_nxt    = fling_y_r;
    if (in_acc) begin
      if (item.report_ready) begin
        priority if (item.event_code == EV_FIRST) begin
          press_x_nxt = item.pos_x;
          press_y_nxt = item.pos_y;
          prev_x_nxt  = item.pos_x;
          prev_y_nxt  = item.pos_y;
          phase_nxt   = PH_FIRST;
        end else if (item.event_code == EV_HELD) begin
          prev_x_nxt = cur_x_r;
          prev_y_nxt = cur_y_r;
          phase_nxt  = PH_HELD;
        end else begin
          phase_nxt = PH_REL;
        end
        cur_x_nxt = item.pos_x;
        cur_y_nxt = item.pos_y;
      end else if (item.event_code == EV_IDLE0 || item.event_code == EV_IDLE2) begin
        phase_nxt = PH_IDLE;
      end
    end
    if (dec_fire) begin
      sm_nxt = sm_dec;
      if (page_ld) press_page_nxt = dpage_r;
      if (upd_fx)  fling_x_nxt    = spd_x;
      if (upd_fy)  fling_y_nxt    = spd_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      phase_r      <= PH_IDLE;
      sm_r         <= SM_UNTOUCHED;
      press_x_r    <= '0;
      press_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      press_page_r <= '0;
      fling_x_r    <= '0;
      fling_y_r    <= '0;
    end else begin
      st_r         <= st_nxt;
      phase_r      <= phase_nxt;
      sm_r         <= sm_nxt;
      press_x_r    <= press_x_nxt;
      press_y_r    <= press_y_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      press_page_r <= press_page_nxt;
      fling_x_r    <= fling_x_nxt;
      fling_y_r    <= fling_y_nxt;
    end
  end

  // Payload holds: page numbers of the word in flight, captured squares
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dpage_r <= item.displayed_page;
      qpage_r <= item.query_page;
    end
    if (st_r == ST_MY) x2_r <= prod[31:0];
    if (st_r == ST_MW) y2_r <= prod[31:0];
  end

  assign res.gesture     = gest;
  assign res.speed_x     = upd_fx ? spd_x : fling_x_r;
  assign res.speed_y     = upd_fy ? spd_y : fling_y_r;
  assign res.touch_phase = phase_r;

  a_fire_in_dec: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (st_r == ST_DEC))
    else $error("result issued outside decision step");

  a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MX) |=> (st_r == ST_MY))
    else $error("multiplier passes out of order");

  a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.gesture == G_CLICK) |-> (phase_r == PH_REL))
    else $error("click reported while not released");

  a_sm_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_DEC) |=> $stable(sm_r))
    else $error("slide mode changed outside decision step");

  a_one_fling: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(upd_fx && upd_fy))
    else $error("both fling speeds updated for one word");

endmodule

// File: rtl/touch_swipe_gesture_classifier_core.sv
// Top level of the touch swipe gesture classifier: stream ports, APB port,
// result register. Depends on tsg_pkg, tsg_cfg, tsg_mul and tsg_ctrl.
//
//   channel  | ports              | word
//   ---------+--------------------+---------------------------------------
//   in       | in_t*              | one touch report, tuser = report_ready
//   out      | out_t*             | one gesture result per report
//   cfg      | cfg_p*             | slide threshold @0x0, angle_factor @0x4
//
// A report runs three passes of the shared multiplier (x^2, y^2, angle*y^2)
// and a classify step on its way to the result register. in_tready is high
// only while the sequencer is idle, so no report is taken before the last is
// classified. Reset (synchronous, rst_n low) clears all gesture state and the
// registers to their defaults. A result waiting on out_tready holds the
// sequencer in the classify step, and in_tready stays low until it frees.
module touch_swipe_gesture_classifier_core import tsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [7:0] event_code, [23:8] pos_x, [39:24] pos_y, [55:40] displayed_page,
  // [71:56] query_page
  input  logic [IN_W-1:0]   in_tdata,
  // [0] report_ready
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [2:0] gesture, [18:3] speed_x, [34:19] speed_y, [36:35] touch_phase,
  // [39:37] zero
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  in_item_t    item;
  res_t        res, res_r;
  logic        in_acc, out_free, res_valid;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] slide_thr;
  logic [3:0]  angle;
  logic        mul_en;
  mul_sel_t    mul_sel;
  logic [15:0] mag_x, mag_y;
  logic [47:0] prod;

  assign item.report_ready   = in_tuser;
  assign item.event_code     = in_tdata[7:0];
  assign item.pos_x          = in_tdata[23:8];
  assign item.pos_y          = in_tdata[39:24];
  assign item.displayed_page = in_tdata[55:40];
  assign item.query_page     = in_tdata[71:56];

  assign in_acc   = in_tvalid & in_tready;
  assign out_free = ~out_valid_r | out_tready;

  assign cfg_pready = 1'b1;

  tsg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .slide_thr (slide_thr),
    .angle     (angle)
  );

  tsg_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .sel    (mul_sel),
    .mag_x  (mag_x),
    .mag_y  (mag_y),
    .angle  (angle),
    .prod_r (prod)
  );

  tsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .item      (item),
    .in_ready  (in_tready),
    .slide_thr (slide_thr),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mul_en    (mul_en),
    .mul_sel   (mul_sel),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .prod      (prod)
  );

  // Hold the word until taken; load a new one when the slot frees
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r.touch_phase, res_r.speed_y, res_r.speed_x, res_r.gesture};

endmodule

// File: tb/tsg_gesture_monitor.sv
`timescale 1ns / 1ps
// Gesture monitor: watches the report, result and register ports of the classifier,
// predicts each gesture word and compares it field by field. Depends on tsg_pkg.
module tsg_gesture_monitor import tsg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  input  logic [31:0]      cfg_prdata,
  input  logic             cfg_pready,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);

  logic [31:0] slide_thr;
  logic [3:0]  angle;
  logic [1:0]  touch_ph;
  logic [1:0]  slide_mode;
  logic [15:0] press_x, press_y, prev_x, prev_y, cur_x, cur_y;
  logic [15:0] press_page;
  logic [15:0] fling_x, fling_y;

  res_t gesture_queue[$];
  int   fails   = 0;
  int   results = 0;

  function automatic logic [31:0] dist_sq(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    logic [31:0] mag;
    d = a - b;
    // 0x8000 negates to itself, which is the right magnitude
    mag = {16'd0, d[15] ? 16'd0 - d : d};
    return mag * mag;
  endfunction

  function automatic void clear_touch();
    slide_thr  = THR_RESET;
    angle      = ANGLE_RESET;
    touch_ph   = PH_IDLE;
    slide_mode = SM_UNTOUCHED;
    press_x = '0; press_y = '0; prev_x = '0; prev_y = '0; cur_x = '0; cur_y = '0;
    press_page = '0;
    fling_x = '0; fling_y = '0;
  endfunction

  task automatic classify_report(input logic rdy, input logic [7:0] code,
                                 input logic [15:0] x, input logic [15:0] y,
                                 input logic [15:0] dpage, input logic [15:0] qpage);
    res_t        r;
    logic [31:0] x2, y2;
    logic        moved, vert;
    logic [2:0]  g;
    if (rdy) begin
      if (code == EV_FIRST) begin
        press_x = x; prev_x = x;
        press_y = y; prev_y = y;
        touch_ph = PH_FIRST;
      end else if (code == EV_HELD) begin
        prev_x = cur_x;
        prev_y = cur_y;
        touch_ph = PH_HELD;
      end else begin
        touch_ph = PH_REL;
      end
      cur_x = x;
      cur_y = y;
    end else if (code == EV_IDLE0 || code == EV_IDLE2) begin
      touch_ph = PH_IDLE;
    end

    x2    = dist_sq(press_x, cur_x);
    y2    = dist_sq(press_y, cur_y);
    moved = (y2 >= slide_thr) || (x2 >= slide_thr);
    vert  = ({4'd0, y2} * angle) >= {4'd0, x2};

    if (touch_ph == PH_IDLE) begin
      slide_mode = SM_UNTOUCHED;
      g = G_UNTOUCHED;
    end else if (touch_ph == PH_FIRST) begin
      press_page = dpage;
      slide_mode = SM_NOSLIDE;
      g = G_NOSLIDE;
    end else if (qpage != press_page) begin
      g = G_NOSLIDE;
    end else if (touch_ph == PH_HELD) begin
      if (slide_mode == SM_NOSLIDE && moved) slide_mode = vert ? SM_VERT : SM_HORZ;
      g = {1'b0, slide_mode};
    end else if (slide_mode == SM_NOSLIDE && !moved) begin
      g = G_CLICK;
    end else begin
      if (slide_mode == SM_NOSLIDE) slide_mode = vert ? SM_VERT : SM_HORZ;
      // untouched falls through to the horizontal fling
      if (slide_mode == SM_VERT) begin
        fling_y = prev_y - cur_y;
        g = G_VFLING;
      end else begin
        fling_x = prev_x - cur_x;
        g = G_HFLING;
      end
    end

    r.gesture     = g;
    r.speed_x     = fling_x;
    r.speed_y     = fling_y;
    r.touch_phase = touch_ph;
    gesture_queue.push_back(r);
  endtask

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    res_t got, want;
    if (!rst_n) begin
      clear_touch();
      gesture_queue.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results++;
        got.gesture     = out_tdata[2:0];
        got.speed_x     = out_tdata[18:3];
        got.speed_y     = out_tdata[34:19];
        got.touch_phase = out_tdata[36:35];
        if (gesture_queue.size() == 0) begin
          fails++;
          $display("%0t ns: unexpected result word, expected none, got %h", $time, out_tdata);
        end else begin
          want = gesture_queue.pop_front();
          compare_field("gesture", int'(want.gesture), int'(got.gesture));
          compare_field("speed_x", int'(want.speed_x), int'(got.speed_x));
          compare_field("speed_y", int'(want.speed_y), int'(got.speed_y));
          compare_field("touch_phase", int'(want.touch_phase), int'(got.touch_phase));
        end
      end
      if (in_tvalid && in_tready)
        classify_report(in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[39:24],
                        in_tdata[55:40], in_tdata[71:56]);
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_SLIDE_THR) slide_thr = cfg_pwdata;
          else angle = cfg_pwdata[3:0];
        end else if (cfg_paddr[2] == REG_SLIDE_THR) begin
          compare_field("slide threshold readback", int'(slide_thr), int'(cfg_prdata));
        end else begin
          compare_field("angle_factor readback", int'({28'd0, angle}), int'(cfg_prdata));
        end
      end
    end
    pending      <= gesture_queue.size();
    fail_count   <= fails;
    results_seen <= results;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the classifier testbench: clock, reset, touch report stimulus, register
// settings and the verdict. Depends on tsg_pkg, tsg_gesture_monitor and the core.
module tb_top import tsg_pkg::*;;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready = 1'b1;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]       cfg_paddr;
  logic [31:0]      cfg_pwdata, cfg_prdata;
  logic             cfg_pready;

  int fail_count, pending, results_seen;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  int reports    = 0;
  int settings   = 0;

  touch_swipe_gesture_classifier_core dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  tsg_gesture_monitor monitor (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .fail_count, .pending, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("touch_swipe_gesture_classifier_core regression: fail");
    $finish;
  end

  // Result side: at random, hold out_tready low in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_report(input logic rdy, input logic [7:0] code,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] dpage, input logic [15:0] qpage);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rdy;
    in_tdata  <= {qpage, dpage, y, x, code};
    do @(posedge clk); while (!in_tready);
    reports++;
  endtask

  // Leaves psel/penable up; the caller drops them after its last access
  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // Drain every outstanding gesture before touching the registers
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] thr, input logic [3:0] angle_f);
    drain();
    reg_access(1'b1, {REG_SLIDE_THR, 2'b00}, thr);
    reg_access(1'b1, {REG_ANGLE, 2'b00}, {28'd0, angle_f});
    reg_access(1'b0, {REG_SLIDE_THR, 2'b00}, '0);
    reg_access(1'b0, {REG_ANGLE, 2'b00}, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    settings++;
  endtask

  function automatic logic [15:0] jitter();
    logic [15:0] mag;
    case ($urandom_range(9))
      0, 1, 2, 3: mag = 16'($urandom_range(0, 30));
      4, 5, 6:    mag = 16'($urandom_range(0, 300));
      7, 8:       mag = 16'($urandom_range(0, 3000));
      default:    return 16'($urandom);
    endcase
    return $urandom_range(1) ? 16'd0 - mag : mag;
  endfunction

  function automatic logic [7:0] release_code();
    logic [7:0] c;
    do c = 8'($urandom); while (c == EV_FIRST || c == EV_HELD);
    return c;
  endfunction

  function automatic logic [7:0] busy_code();
    logic [7:0] c;
    do c = 8'($urandom); while (c == EV_IDLE0 || c == EV_IDLE2);
    return c;
  endfunction

  // Mostly whole press/hold/release strokes, with some noise reports mixed in
  task automatic touch_traffic(input int count);
    logic [15:0] bx, by, page;
    logic [7:0]  c;
    int          target;
    target = reports + count;
    while (reports < target) begin
      if ($urandom_range(99) < 15) begin
        c = $urandom_range(1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        send_report(1'($urandom_range(1)), c, 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
      end else begin
        bx   = 16'($urandom);
        by   = 16'($urandom);
        page = 16'($urandom);
        send_report(1'b1, EV_FIRST, bx, by, page, 16'($urandom));
        if ($urandom_range(9) == 0) begin
          page = 16'($urandom);
          send_report(1'b0, EV_FIRST, 16'($urandom), 16'($urandom), page, 16'($urandom));
        end
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(9))
            0: send_report(1'b0, busy_code(), 16'($urandom), 16'($urandom),
                           16'($urandom), page);
            1: send_report(1'b1, EV_HELD, bx + jitter(), by + jitter(), 16'($urandom),
                           page ^ (16'd1 << $urandom_range(15)));
            default: send_report(1'b1, EV_HELD, bx + jitter(), by + jitter(),
                                 16'($urandom), page);
          endcase
        end
        send_report(1'b1, release_code(), bx + jitter(), by + jitter(), 16'($urandom), page);
        if ($urandom_range(9) < 3)
          send_report(1'b0, $urandom_range(1) ? busy_code() : EV_IDLE2,
                      16'($urandom), 16'($urandom), 16'($urandom), page);
      end
    end
  endtask

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 20;
      default: return 45;
    endcase
  endfunction

  initial begin : stimulus
    int directed;
    int waited;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strokes at the reset settings, then with the angle factor at zero
    gap_pct   = 30;
    stall_pct = 30;
    send_report(1'b0, EV_IDLE0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_report(1'b1, EV_HELD, 16'h1234, 16'h00ff, 16'h0000, 16'h0000);   // held, untouched
    send_report(1'b1, 8'h80, 16'h0010, 16'h0020, 16'h0000, 16'h0000);     // horizontal fling
    send_report(1'b1, EV_FIRST, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
    send_report(1'b1, EV_HELD, 16'h8000, 16'h8000, 16'h0000, 16'h0000);   // wrong page
    send_report(1'b1, EV_HELD, 16'h8000, 16'h8000, 16'h0000, 16'hffff);   // distance wraps
    send_report(1'b1, EV_HELD, 16'h7fff, 16'h7fff, 16'h0000, 16'hffff);
    send_report(1'b1, 8'hff, 16'h7fff, 16'h8001, 16'h0000, 16'hffff);     // vertical fling
    send_report(1'b0, 8'hff, 16'($urandom), 16'($urandom), 16'($urandom),
                16'hffff);                                                // stale, re-evaluate
    send_report(1'b0, EV_IDLE2, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    send_report(1'b1, EV_FIRST, 16'h0100, 16'h0100, 16'h0005, 16'h0000);
    send_report(1'b0, EV_FIRST, 16'h0000, 16'h0000, 16'h0007, 16'h0000); // relatch page
    send_report(1'b1, EV_IDLE2, 16'h0100, 16'h0100, 16'h0000, 16'h0007); // click
    send_report(1'b1, EV_FIRST, 16'hfff0, 16'h0000, 16'h1234, 16'h0000);
    send_report(1'b1, EV_HELD, 16'h0010, 16'h0001, 16'h0000, 16'h1234);   // horizontal
    send_report(1'b1, EV_HELD, 16'h0020, 16'h0002, 16'h0000, 16'h1234);
    send_report(1'b1, EV_IDLE0, 16'h0030, 16'h0003, 16'h0000, 16'h1234); // horizontal fling
    send_report(1'b1, EV_FIRST, 16'h7fff, 16'h7fff, 16'habcd, 16'h0000);
    send_report(1'b1, EV_HELD, 16'h7fff, 16'h7ffe, 16'h0000, 16'habcd);   // below threshold
    send_report(1'b1, 8'h55, 16'h7fff, 16'h7fd0, 16'h0000, 16'habcd);     // decide on release
    load_settings(THR_RESET, 4'd0);
    send_report(1'b1, EV_FIRST, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
    send_report(1'b1, EV_HELD, 16'h0000, 16'h0064, 16'h0000, 16'h0001);   // dx zero: vertical
    send_report(1'b1, EV_FIRST, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
    send_report(1'b1, EV_HELD, 16'h001e, 16'h0064, 16'h0000, 16'h0001);   // otherwise horizontal
    directed = reports;

    // Random strokes under a spread of settings, extremes included
    gap_pct = pick_pct(); stall_pct = pick_pct();
    load_settings(32'd0, 4'd15);
    touch_traffic(190);
    gap_pct = pick_pct(); stall_pct = pick_pct();
    load_settings(32'hffff_ffff, 4'd1);
    touch_traffic(180);
    gap_pct = pick_pct(); stall_pct = pick_pct();
    load_settings(32'd100, 4'd0);
    touch_traffic(180);
    gap_pct = pick_pct(); stall_pct = pick_pct();
    load_settings(32'd2500, 4'd7);
    touch_traffic(190);
    gap_pct = pick_pct(); stall_pct = pick_pct();
    load_settings($urandom_range(0, 90000), 4'($urandom_range(1, 15)));
    touch_traffic(190);
    gap_pct   = 0;
    stall_pct = 0;
    load_settings(THR_RESET, ANGLE_RESET);
    touch_traffic(190);

    in_tvalid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    $display("Covered %0d touch reports (%0d directed) under %0d register settings;",
             reports, directed, settings + 1);
    $display("%0d gesture words compared, %0d still outstanding.", results_seen, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("touch_swipe_gesture_classifier_core regression: pass");
    end else begin
      $display("touch_swipe_gesture_classifier_core regression: fail");
    end
    $finish;
  end

endmodule

// File: touch_swipe_gesture_classifier_core.f
rtl/tsg_pkg.sv
rtl/tsg_cfg.sv
rtl/tsg_mul.sv
rtl/tsg_ctrl.sv
rtl/touch_swipe_gesture_classifier_core.sv
tb/tsg_gesture_monitor.sv
tb/tb_top.sv
